@@ src/mft_pkg.sv @@
// Shared types, codes and reset values for the motor feedback tracker.
package mft_pkg;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_RESOLUTION = 2'd0,
        REG_TRACK      = 2'd1,
        REG_TIMEOUT    = 2'd2,
        REG_STALL      = 2'd3
    } reg_index_t;

    // Item kind carried on tuser
    typedef enum logic {
        MODE_FRAME = 1'b0,
        MODE_TICK  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OFFLINE = 2'd0,
        STATUS_STOPPED = 2'd1,
        STATUS_RUNNING = 2'd2
    } status_t;

    localparam int CfgDataWidth = 17;
    localparam int InDataWidth  = 56;
    localparam int OutDataWidth = 96;

    localparam logic [16:0] ResolutionReset = 17'd8192;
    localparam logic        TrackReset      = 1'b0;
    localparam logic [15:0] TimeoutReset    = 16'd50;
    localparam logic [14:0] StallReset      = 15'd50;
    localparam logic [15:0] SilenceMax      = 16'hFFFF;

    typedef struct packed {
        logic [16:0] resolution;
        logic        track;
        logic [15:0] timeout;
        logic [14:0] stall;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  angle_high;
        logic [7:0]  angle_low;
        logic [7:0]  speed_high;
        logic [7:0]  speed_low;
        logic [7:0]  current_high;
        logic [7:0]  current_low;
        logic [7:0]  temperature_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] speed;
        logic [15:0] current;
        logic [7:0]  temperature;
        logic [31:0] position;
        status_t     motor_status;
    } result_t;

endpackage

@@ src/mft_cfg.sv @@
// Configuration register file of the motor feedback tracker.
module mft_cfg
    import mft_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_en,
    input  logic [1:0]              wr_index,
    input  logic [CfgDataWidth-1:0] wr_data,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_index_t'(wr_index))
                REG_RESOLUTION: cfg_next.resolution = wr_data;
                REG_TRACK:      cfg_next.track      = wr_data[0];
                REG_TIMEOUT:    cfg_next.timeout    = wr_data[15:0];
                REG_STALL:      cfg_next.stall      = wr_data[14:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.resolution <= ResolutionReset;
            cfg_reg.track      <= TrackReset;
            cfg_reg.timeout    <= TimeoutReset;
            cfg_reg.stall      <= StallReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/mft_tracker.sv @@
// Tracker state and the single-pass frame decode, unwrap and status logic.
module mft_tracker
    import mft_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     advance,
    input  in_item_t item,
    input  cfg_t     cfg,
    output result_t  result
);

    logic [15:0] last_angle_reg, last_angle_next;
    logic        first_pending_reg, first_pending_next;
    logic [31:0] position_reg, position_next;
    logic [15:0] angle_reg, angle_next;
    logic [15:0] speed_reg, speed_next;
    logic [15:0] current_reg, current_next;
    logic [7:0]  temp_reg, temp_next;
    logic [15:0] silence_reg, silence_next;
    status_t     status_reg, status_next;

    logic [15:0]        ang;
    logic signed [16:0] diff;
    logic [16:0]        diff_mag;
    logic [15:0]        half_res;
    logic signed [17:0] diff_fix;
    logic [15:0]        silence_inc;
    logic [16:0]        speed_mag;

    assign ang      = {item.angle_high, item.angle_low};
    assign diff     = signed'({ang[15], ang}) - signed'({last_angle_reg[15], last_angle_reg});
    assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
    assign half_res = cfg.resolution[16:1];

    always_comb begin
        if (diff_mag > {1'b0, half_res}) begin
            if (diff[16]) begin
                diff_fix = signed'({diff[16], diff}) + signed'({1'b0, cfg.resolution});
            end else begin
                diff_fix = signed'({diff[16], diff}) - signed'({1'b0, cfg.resolution});
            end
        end else begin
            diff_fix = signed'({diff[16], diff});
        end
    end

    // Tick path: saturating count, then classify from the stored speed
    assign silence_inc = (silence_reg == SilenceMax) ? silence_reg : silence_reg + 16'd1;
    assign speed_mag   = speed_reg[15] ? (17'h10000 - {1'b0, speed_reg}) : {1'b0, speed_reg};

    always_comb begin
        last_angle_next    = last_angle_reg;
        first_pending_next = first_pending_reg;
        position_next      = position_reg;
        angle_next         = angle_reg;
        speed_next         = speed_reg;
        current_next       = current_reg;
        temp_next          = temp_reg;
        silence_next       = silence_reg;
        status_next        = status_reg;

        unique case (item.mode)
            MODE_FRAME: begin
                angle_next   = ang;
                speed_next   = {item.speed_high, item.speed_low};
                current_next = {item.current_high, item.current_low};
                temp_next    = item.temperature_byte;
                silence_next = '0;
                if (!cfg.track) begin
                    position_next      = '0;
                    first_pending_next = 1'b1;
                end else if (first_pending_reg) begin
                    last_angle_next    = ang;
                    first_pending_next = 1'b0;
                end else begin
                    position_next   = position_reg + {{14{diff_fix[17]}}, diff_fix};
                    last_angle_next = ang;
                end
            end
            MODE_TICK: begin
                silence_next = silence_inc;
                if (silence_inc > cfg.timeout) begin
                    status_next = STATUS_OFFLINE;
                end else if (speed_mag < {2'b00, cfg.stall}) begin
                    status_next = STATUS_STOPPED;
                end else begin
                    status_next = STATUS_RUNNING;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_angle_reg    <= '0;
            first_pending_reg <= 1'b1;
            position_reg      <= '0;
            angle_reg         <= '0;
            speed_reg         <= '0;
            current_reg       <= '0;
            temp_reg          <= '0;
            silence_reg       <= SilenceMax;
            status_reg        <= STATUS_OFFLINE;
        end else if (advance) begin
            last_angle_reg    <= last_angle_next;
            first_pending_reg <= first_pending_next;
            position_reg      <= position_next;
            angle_reg         <= angle_next;
            speed_reg         <= speed_next;
            current_reg       <= current_next;
            temp_reg          <= temp_next;
            silence_reg       <= silence_next;
            status_reg        <= status_next;
        end
    end

    // The result reflects the state after this item
    assign result.angle        = angle_next;
    assign result.speed        = speed_next;
    assign result.current      = current_next;
    assign result.temperature  = temp_next;
    assign result.position     = position_next;
    assign result.motor_status = status_next;

endmodule

@@ src/motor_feedback_tracker_unit.sv @@
// Top level of the motor feedback tracker: input register, tracker, result register.
//
// Usage:
//   The s_ channel carries one item per transaction: tuser = 0 marks a 7-byte
//   motor feedback frame in tdata, tuser = 1 a one-millisecond tick (tdata
//   ignored). Every item yields exactly one result transaction on the m_
//   channel with the latest decoded angle, speed, current, temperature, the
//   multi-turn position and the motor status.
//   The cfg channel writes one register per transaction (cfg_ready is always
//   high); write only while no item is in flight.
//   An accepted item goes into the input register, then into the result
//   register when that is free, and its result is then on the m_ channel.
//   Throughput: one item per cycle while m_tready is high; the decode, wrap
//   correction and 32-bit position add fit between the two registers.
//   When m_tready is low, the result register holds and one more item can
//   wait in the input register; s_tready drops only when both are full.
//   Reset (aresetn low, synchronous) empties both registers, restores the
//   configuration defaults, marks the motor offline with a saturated
//   silence count and zero position, and arms the first-sample flag.
module motor_feedback_tracker_unit
    import mft_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // angle_high, angle_low, speed_high, speed_low, current_high,
    // current_low, temperature_byte (8 bits each, from bit 0 up)
    input  logic [InDataWidth-1:0]  s_tdata,
    // mode
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // angle[15:0], speed[31:16], current[47:32], temperature[55:48],
    // position[87:56], motor_status[89:88], zero fill [95:90]
    output logic [OutDataWidth-1:0] m_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data
);

    in_item_t in_item_reg;
    logic     in_vld_reg;
    result_t  out_res_reg;
    logic     out_vld_reg;
    cfg_t     cfg;
    result_t  result;
    logic     out_free;
    logic     advance;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_vld_reg || m_tready;
    assign advance   = in_vld_reg && out_free;
    assign s_tready  = !in_vld_reg || out_free;

    mft_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    mft_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.mode             <= mode_t'(s_tuser);
            in_item_reg.angle_high       <= s_tdata[7:0];
            in_item_reg.angle_low        <= s_tdata[15:8];
            in_item_reg.speed_high       <= s_tdata[23:16];
            in_item_reg.speed_low        <= s_tdata[31:24];
            in_item_reg.current_high     <= s_tdata[39:32];
            in_item_reg.current_low      <= s_tdata[47:40];
            in_item_reg.temperature_byte <= s_tdata[55:48];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, out_res_reg.motor_status, out_res_reg.position,
                       out_res_reg.temperature, out_res_reg.current,
                       out_res_reg.speed, out_res_reg.angle};

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed item did not reach the result register");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_vld_reg && out_vld_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_res_reg.motor_status <= STATUS_RUNNING)
        else $error("undefined motor status code");

endmodule

@@ tb/mft_result_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the motor feedback tracker: follows the channels, predicts every result and compares it.
module mft_result_checker
    import mft_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [InDataWidth-1:0]  s_tdata,
    input  logic                    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OutDataWidth-1:0] m_tdata,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    output int                      mismatch_count,
    output int                      results_owed
);

    result_t     owed_q[$];
    cfg_t        cfg_shadow;

    logic [15:0] prev_angle;
    bit          first_pending;
    logic [31:0] pos_acc;
    logic [15:0] fb_angle;
    logic [15:0] fb_speed;
    logic [15:0] fb_current;
    logic [7:0]  fb_temp;
    logic [15:0] quiet_ms;
    status_t     status_now;

    initial begin
        mismatch_count = 0;
        results_owed   = 0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void restart_tracker();
        cfg_shadow    = '{ResolutionReset, TrackReset, TimeoutReset, StallReset};
        prev_angle    = '0;
        first_pending = 1'b1;
        pos_acc       = '0;
        fb_angle      = '0;
        fb_speed      = '0;
        fb_current    = '0;
        fb_temp       = '0;
        quiet_ms      = SilenceMax;
        status_now    = STATUS_OFFLINE;
    endfunction

    function automatic void decode_frame(in_item_t it);
        int a;
        int b;
        int d;
        int span;
        int half;
        int mag;
        fb_angle   = {it.angle_high, it.angle_low};
        fb_speed   = {it.speed_high, it.speed_low};
        fb_current = {it.current_high, it.current_low};
        fb_temp    = it.temperature_byte;
        quiet_ms   = '0;
        if (!cfg_shadow.track) begin
            pos_acc       = '0;
            first_pending = 1'b1;
            return;
        end
        if (first_pending) begin
            prev_angle    = fb_angle;
            first_pending = 1'b0;
            return;
        end
        a    = $signed(fb_angle);
        b    = $signed(prev_angle);
        d    = a - b;
        span = cfg_shadow.resolution;
        half = span / 2;
        mag  = (d < 0) ? -d : d;
        // a jump over half a turn is taken as a wrap through zero
        if (mag > half) begin
            if (d > 0) d = d - span;
            else d = d + span;
        end
        pos_acc    = pos_acc + d;
        prev_angle = fb_angle;
    endfunction

    function automatic void classify_tick();
        int s;
        if (quiet_ms != SilenceMax) quiet_ms = quiet_ms + 16'd1;
        if (quiet_ms > cfg_shadow.timeout) begin
            status_now = STATUS_OFFLINE;
        end else begin
            s = $signed(fb_speed);
            if (s < 0) s = -s;
            status_now = (s < int'(cfg_shadow.stall)) ? STATUS_STOPPED : STATUS_RUNNING;
        end
    endfunction

    always @(posedge aclk) begin : watch
        in_item_t it;
        result_t  want;
        result_t  got;
        if (!aresetn) begin
            restart_tracker();
            owed_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_RESOLUTION: cfg_shadow.resolution = cfg_data;
                    REG_TRACK:      cfg_shadow.track      = cfg_data[0];
                    REG_TIMEOUT:    cfg_shadow.timeout    = cfg_data[15:0];
                    REG_STALL:      cfg_shadow.stall      = cfg_data[14:0];
                    default: ;
                endcase
            end
            // retire first so an empty queue can never match a same-cycle push
            if (m_tvalid && m_tready) begin
                got.angle        = m_tdata[15:0];
                got.speed        = m_tdata[31:16];
                got.current      = m_tdata[47:32];
                got.temperature  = m_tdata[55:48];
                got.position     = m_tdata[87:56];
                got.motor_status = status_t'(m_tdata[89:88]);
                if (owed_q.size() == 0) begin
                    report_mismatch("unexpected transaction", m_tdata[31:0], '0);
                end else begin
                    want = owed_q.pop_front();
                    if (got.angle !== want.angle)
                        report_mismatch("angle", got.angle, want.angle);
                    if (got.speed !== want.speed)
                        report_mismatch("speed", got.speed, want.speed);
                    if (got.current !== want.current)
                        report_mismatch("current", got.current, want.current);
                    if (got.temperature !== want.temperature)
                        report_mismatch("temperature", got.temperature, want.temperature);
                    if (got.position !== want.position)
                        report_mismatch("position", got.position, want.position);
                    if (got.motor_status !== want.motor_status)
                        report_mismatch("motor_status", got.motor_status, want.motor_status);
                end
            end
            if (s_tvalid && s_tready) begin
                it.mode             = mode_t'(s_tuser);
                it.angle_high       = s_tdata[7:0];
                it.angle_low        = s_tdata[15:8];
                it.speed_high       = s_tdata[23:16];
                it.speed_low        = s_tdata[31:24];
                it.current_high     = s_tdata[39:32];
                it.current_low      = s_tdata[47:40];
                it.temperature_byte = s_tdata[55:48];
                if (it.mode == MODE_TICK) classify_tick();
                else decode_frame(it);
                want.angle        = fb_angle;
                want.speed        = fb_speed;
                want.current      = fb_current;
                want.temperature  = fb_temp;
                want.position     = pos_acc;
                want.motor_status = status_now;
                owed_q.push_back(want);
            end
        end
        results_owed <= owed_q.size();
    end

endmodule

@@ tb/tb_motor_feedback_tracker_unit.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the motor feedback tracker; checking sits in mft_result_checker.
module tb_motor_feedback_tracker_unit;
    import mft_pkg::*;

    localparam int ClkPeriod     = 8;
    localparam int CycleLimit    = 400000;
    localparam int ItemsPerPhase = 145;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [InDataWidth-1:0]  s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OutDataWidth-1:0] m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    reg_index_t              cfg_index = REG_RESOLUTION;
    logic [CfgDataWidth-1:0] cfg_data  = '0;

    int mismatch_count;
    int results_owed;
    int src_idle_pct  = 24;
    int sink_idle_pct = 71;
    int enc_pos       = 0;
    int cycle_count   = 0;

    always #(ClkPeriod / 2) aclk = ~aclk;

    motor_feedback_tracker_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mft_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // valid stays high into the next transaction unless idle cycles are drawn
    task automatic push_item(mode_t kind, logic [InDataWidth-1:0] payload);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_frame(logic [15:0] ang, logic [15:0] spd, logic [15:0] cur,
                              logic [7:0] tmp);
        push_item(MODE_FRAME, {tmp, cur[7:0], cur[15:8], spd[7:0], spd[15:8],
                               ang[7:0], ang[15:8]});
    endtask

    task automatic send_tick();
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        push_item(MODE_TICK, junk[InDataWidth-1:0]);
    endtask

    task automatic send_noise();
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        push_item(mode_t'($urandom_range(1)), junk[InDataWidth-1:0]);
    endtask

    // encoder moving within one turn, speed often right at the stall threshold
    task automatic send_moving_frame(int span, int stall);
        int          step;
        logic [15:0] spd;
        case ($urandom_range(2))
            0: step = $urandom_range(span / 8);
            1: step = span - $urandom_range(span / 8);
            default: step = $urandom_range(span - 1);
        endcase
        enc_pos = (enc_pos + step) % span;
        if ($urandom_range(1)) begin
            spd = 16'(stall + int'($urandom_range(2)) - 1);
            if ($urandom_range(1)) spd = -spd;
        end else begin
            spd = 16'($urandom);
        end
        send_frame(enc_pos[15:0], spd, 16'($urandom), 8'($urandom));
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CfgDataWidth-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_config(logic [16:0] res, logic trk, logic [15:0] tmo, logic [14:0] stl);
        quiesce();
        write_reg(REG_RESOLUTION, res);
        write_reg(REG_TRACK, {16'd0, trk});
        write_reg(REG_TIMEOUT, {1'b0, tmo});
        write_reg(REG_STALL, {2'b0, stl});
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [16:0] res_v;
        logic        trk_v;
        logic [15:0] tmo_v;
        logic [14:0] stl_v;
        int          span;
        int          n_items;
        int          seg_kind;
        int          seg_len;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset state and decode extremes, tracking off
        send_tick();
        send_frame(16'h7FFF, 16'h8000, 16'h8000, 8'h80);
        send_tick();
        send_frame(16'h8000, 16'd49, 16'h7FFF, 8'h7F);
        send_tick();
        send_frame(16'h0000, 16'hFFCE, 16'h0000, 8'h00);
        send_tick();

        // wrap correction around half a turn
        set_config(17'd8192, 1'b1, 16'd50, 15'd50);
        send_frame(16'd100, 16'd1000, 16'd5, 8'd20);
        send_frame(16'd8000, 16'd1000, 16'd5, 8'd20);
        send_frame(16'd100, 16'd1000, 16'd5, 8'd20);
        send_frame(16'd4196, 16'd1000, 16'd5, 8'd20);
        send_frame(16'd100, 16'd1000, 16'd5, 8'd20);
        send_frame(16'd4197, 16'd1000, 16'd5, 8'd20);

        // tracking off clears position and re-arms the first sample
        set_config(17'd8192, 1'b0, 16'd50, 15'd50);
        send_frame(16'd300, 16'd1000, 16'd5, 8'd20);
        set_config(17'd8192, 1'b1, 16'd0, 15'd0);
        send_frame(16'd500, 16'd1000, 16'd5, 8'd20);
        send_tick();

        // tiny resolution, signed angle extremes
        set_config(17'd2, 1'b1, 16'd1, 15'd0);
        send_frame(16'h8000, 16'd0, 16'd0, 8'd0);
        send_frame(16'h7FFF, 16'd0, 16'd0, 8'd0);
        send_frame(16'h7FFE, 16'd0, 16'd0, 8'd0);
        send_tick();
        send_tick();

        // zero resolution leaves differences uncorrected
        set_config(17'd0, 1'b1, 16'd1, 15'h7FFF);
        send_frame(16'h0000, 16'd0, 16'd0, 8'd0);
        send_frame(16'hFFFF, 16'd0, 16'd0, 8'd0);
        send_tick();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin res_v = 17'd8192;  trk_v = 1'b1; tmo_v = 16'd5;     stl_v = 15'd50;    end
                1: begin res_v = 17'd65536; trk_v = 1'b1; tmo_v = 16'd1;     stl_v = 15'h7FFF;  end
                2: begin res_v = 17'd2;     trk_v = 1'b1; tmo_v = 16'd3;     stl_v = 15'd0;     end
                3: begin res_v = 17'h1FFFF; trk_v = 1'b1; tmo_v = 16'hFFFF;  stl_v = 15'd1000;  end
                4: begin res_v = 17'd0;     trk_v = 1'b1; tmo_v = 16'd0;     stl_v = 15'd100;   end
                5: begin
                    res_v = 17'($urandom_range(65536, 2));
                    trk_v = 1'b0;
                    tmo_v = 16'($urandom_range(10, 1));
                    stl_v = 15'($urandom);
                end
                6: begin res_v = 17'd4096;  trk_v = 1'b1; tmo_v = 16'd50;    stl_v = 15'd50;    end
                7: begin
                    res_v = 17'($urandom_range(65536, 2));
                    trk_v = 1'($urandom_range(1));
                    tmo_v = 16'($urandom_range(20, 1));
                    stl_v = 15'($urandom);
                end
                default: begin res_v = 17'd8192; trk_v = 1'b1; tmo_v = 16'd8; stl_v = 15'd300; end
            endcase
            src_idle_pct  = (ph < 3) ? 24 : (ph < 6) ? 71 : 0;
            sink_idle_pct = (ph < 3) ? 71 : (ph < 6) ? 24 : 0;
            set_config(res_v, trk_v, tmo_v, stl_v);

            span    = (res_v == 0 || res_v > 17'd65536) ? 65536 : int'(res_v);
            enc_pos = $urandom_range(span - 1);
            n_items = 0;
            while (n_items < ItemsPerPhase) begin
                seg_kind = $urandom_range(99);
                if (seg_kind < 60) begin
                    seg_len = $urandom_range(20, 5);
                    repeat (seg_len) begin
                        if ($urandom_range(99) < 70) send_moving_frame(span, int'(stl_v));
                        else send_tick();
                    end
                end else if (seg_kind < 80) begin
                    // silence long enough to drop offline where the timeout allows
                    seg_len = (tmo_v <= 30) ? int'(tmo_v) + $urandom_range(3, 1)
                                            : $urandom_range(8, 3);
                    repeat (seg_len) send_tick();
                end else begin
                    seg_len = $urandom_range(5, 1);
                    repeat (seg_len) send_noise();
                end
                n_items += seg_len;
            end
        end

        quiesce();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
